[hw/rtl/sm4_pkg.sv]
// Shared constants, tables and round functions of the SM4 cipher core.
`default_nettype none

package sm4_pkg;

    // Cipher geometry
    localparam int unsigned ROUNDS   = 32;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLOCK_W  = 128;
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned RND_IDX_W = 5;

    // Configuration port geometry: three registers on an 8-byte stride
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_KEY_HIGH     = 2'd0;
    localparam reg_idx_t REG_KEY_LOW      = 2'd1;
    localparam reg_idx_t REG_DECRYPT_MODE = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BLOCK_W-1:0] block_t;

    // Key schedule system parameters
    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Apply the S-box to each byte of a word
    function automatic word_t sub_word(input word_t v);
        word_t r;
        r = {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
        return r;
    endfunction

    function automatic word_t rol(input word_t v, input int unsigned n);
        word_t r;
        r = (v << n) | (v >> (WORD_W - n));
        return r;
    endfunction

    // Cipher round transform: S-box then rotate-2/10/18/24 diffusion
    function automatic word_t round_t(input word_t v);
        word_t b;
        b = sub_word(v);
        return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    endfunction

    // Key schedule transform: S-box then rotate-13/23 diffusion
    function automatic word_t key_t(input word_t v);
        word_t b;
        b = sub_word(v);
        return b ^ rol(b, 13) ^ rol(b, 23);
    endfunction

    // CK constant for round i: byte j is (4*i + j) * 7 mod 256
    function automatic word_t ck_word(input logic [RND_IDX_W-1:0] i);
        word_t w;
        for (int j = 0; j < 4; j++) begin
            w[31-8*j -: 8] = 8'({i, 2'(j)}) * 8'd7;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sm4_round_cell.sv]
// One cipher round cell: applies a round to the upstream state and holds the result.
`default_nettype none

module sm4_round_cell (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   up_valid,
    input  wire sm4_pkg::block_t        up_state,
    output logic                        up_ready,
    input  wire sm4_pkg::word_t         round_key,
    output logic                        dn_valid,
    output sm4_pkg::block_t             dn_state,
    input  wire logic                   dn_ready
);

    logic            valid_reg;
    sm4_pkg::block_t state_reg;
    sm4_pkg::block_t state_next;
    sm4_pkg::word_t  x0, x1, x2, x3;

    // Shift the four words and append the new one
    always_comb begin
        x0 = up_state[127:96];
        x1 = up_state[95:64];
        x2 = up_state[63:32];
        x3 = up_state[31:0];
        state_next = {x1, x2, x3, x0 ^ sm4_pkg::round_t(x1 ^ x2 ^ x3 ^ round_key)};
    end

    // Take a new beat whenever this cell is empty or its content moves on
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            state_reg <= state_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_state = state_reg;

endmodule

`default_nettype wire

[hw/rtl/sm4_key_sched.sv]
// Iterative key expander: derives the 32 round keys, one per cycle.
`default_nettype none

module sm4_key_sched (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        start,
    input  wire logic [sm4_pkg::HALF_W-1:0]                  key_high,
    input  wire logic [sm4_pkg::HALF_W-1:0]                  key_low,
    output logic                                             busy,
    output sm4_pkg::word_t                                   round_keys [sm4_pkg::ROUNDS]
);

    logic                             busy_reg;
    logic [sm4_pkg::RND_IDX_W-1:0]    cnt_reg;
    sm4_pkg::word_t                   w_reg [4];
    sm4_pkg::word_t                   rk_reg [sm4_pkg::ROUNDS];
    sm4_pkg::word_t                   rk_next;

    // Next round key from the sliding four-word window
    always_comb begin
        rk_next = w_reg[0] ^ sm4_pkg::key_t(w_reg[1] ^ w_reg[2] ^ w_reg[3] ^
                                            sm4_pkg::ck_word(cnt_reg));
    end

    // Control: restart on a key load, stop after the last round key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == sm4_pkg::RND_IDX_W'(sm4_pkg::ROUNDS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Window: load key xor FK, then advance one round a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            w_reg[0] <= key_high[63:32] ^ sm4_pkg::FK0;
            w_reg[1] <= key_high[31:0]  ^ sm4_pkg::FK1;
            w_reg[2] <= key_low[63:32]  ^ sm4_pkg::FK2;
            w_reg[3] <= key_low[31:0]   ^ sm4_pkg::FK3;
        end else if (busy_reg) begin
            w_reg[0] <= w_reg[1];
            w_reg[1] <= w_reg[2];
            w_reg[2] <= w_reg[3];
            w_reg[3] <= rk_next;
        end
    end

    // Store each round key as it is produced
    always_ff @(posedge aclk) begin
        if (!start && busy_reg) begin
            rk_reg[cnt_reg] <= rk_next;
        end
    end

    assign busy       = busy_reg;
    assign round_keys = rk_reg;

endmodule

`default_nettype wire

[hw/rtl/sm4_block_cipher_unit.sv]
// Top level of the SM4 cipher core: config registers, key expander and round chain.
//
// Usage:
//   Configure key_high (0x00), key_low (0x08) and decrypt_mode (0x10) over the
//   APB port, 64-bit data, pready always high. Each write to a key register
//   restarts round key expansion; s_ready stays low until it finishes. A mode
//   write takes effect at once.
//   Input beats (s_block_high/s_block_low, valid/ready) carry one 128-bit
//   block each; output beats (m_result_high/m_result_low) carry its result.
//   The datapath is a chain of 32 round cells, one round per cell, each
//   holding its result in a register; a new block can be accepted every
//   cycle while the chain is not stalled by m_ready and the keys are ready.
//   After reset all registers are zero and the expander runs once for the
//   zero key, so the first block is taken only once that expansion finishes.
//   When m_ready is low, cells fill up behind the held output; empty cells
//   still accept beats, and s_ready drops only once the chain is full.
`default_nettype none

module sm4_block_cipher_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sm4_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [sm4_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sm4_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready,
    // Input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [sm4_pkg::HALF_W-1:0]          s_block_high,
    input  wire logic [sm4_pkg::HALF_W-1:0]          s_block_low,
    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sm4_pkg::HALF_W-1:0]               m_result_high,
    output logic [sm4_pkg::HALF_W-1:0]               m_result_low
);

    logic [sm4_pkg::HALF_W-1:0] key_high_reg;
    logic [sm4_pkg::HALF_W-1:0] key_low_reg;
    logic                       decrypt_mode_reg;
    logic                       kick_reg;
    logic                       wr_en;
    sm4_pkg::reg_idx_t          reg_idx;
    logic                       ks_busy;
    logic                       ks_ready;
    sm4_pkg::word_t             round_keys [sm4_pkg::ROUNDS];

    logic                       chain_valid [sm4_pkg::ROUNDS+1];
    logic                       chain_ready [sm4_pkg::ROUNDS+1];
    sm4_pkg::block_t            chain_state [sm4_pkg::ROUNDS+1];
    sm4_pkg::block_t            last_state;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            decrypt_mode_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sm4_pkg::REG_KEY_HIGH:     key_high_reg     <= pwdata;
                sm4_pkg::REG_KEY_LOW:      key_low_reg      <= pwdata;
                sm4_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            sm4_pkg::REG_KEY_HIGH:     prdata = key_high_reg;
            sm4_pkg::REG_KEY_LOW:      prdata = key_low_reg;
            sm4_pkg::REG_DECRYPT_MODE: prdata = {63'd0, decrypt_mode_reg};
            default:                   prdata = '0;
        endcase
    end

    // Restart key expansion after reset and after each key write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_reg <= 1'b1;
        end else begin
            kick_reg <= wr_en && (reg_idx == sm4_pkg::REG_KEY_HIGH ||
                                  reg_idx == sm4_pkg::REG_KEY_LOW);
        end
    end

    sm4_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (kick_reg),
        .key_high   (key_high_reg),
        .key_low    (key_low_reg),
        .busy       (ks_busy),
        .round_keys (round_keys)
    );

    assign ks_ready = !ks_busy && !kick_reg;

    // Feed the head of the chain; hold input while keys are not ready
    assign chain_valid[0] = s_valid && ks_ready;
    assign chain_state[0] = {s_block_high, s_block_low};
    assign s_ready        = chain_ready[0] && ks_ready;

    // Row of round cells; decryption walks the round keys backwards
    for (genvar i = 0; i < sm4_pkg::ROUNDS; i++) begin : g_round
        sm4_pkg::word_t cell_key;
        assign cell_key = decrypt_mode_reg ? round_keys[sm4_pkg::ROUNDS-1-i] : round_keys[i];

        sm4_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .up_valid  (chain_valid[i]),
            .up_state  (chain_state[i]),
            .up_ready  (chain_ready[i]),
            .round_key (cell_key),
            .dn_valid  (chain_valid[i+1]),
            .dn_state  (chain_state[i+1]),
            .dn_ready  (chain_ready[i+1])
        );
    end

    // Last cell is the output register; emit the word-reversed state
    assign chain_ready[sm4_pkg::ROUNDS] = m_ready;
    assign last_state    = chain_state[sm4_pkg::ROUNDS];
    assign m_valid       = chain_valid[sm4_pkg::ROUNDS];
    assign m_result_high = {last_state[31:0], last_state[63:32]};
    assign m_result_low  = {last_state[95:64], last_state[127:96]};

endmodule

`default_nettype wire
